FILE: rtl/adc_channel_sample_cache_top_macros.svh
// assertion macros used by the sample cache top
`ifndef ADC_CHANNEL_SAMPLE_CACHE_TOP_MACROS_SVH
`define ADC_CHANNEL_SAMPLE_CACHE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ACSC_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sample cache check failed");

// next-cycle implication, sampled on clk, off during reset
`define ACSC_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sample cache check failed");

`endif

FILE: rtl/acsc_pkg.sv
// package: types and constants of the adc channel sample cache
`default_nettype none

package acsc_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int MAX_OUT          = 8;
    localparam int CMD_W            = 2;
    localparam int WORD_W           = 32;
    localparam int MASK_W           = 8;
    localparam int COUNT_W          = 4;
    localparam int SAMPLE_W         = 16;
    localparam int CHAN_W           = 3;
    localparam int SAMPLE_LSB       = 8;
    localparam int WORD_CHAN_W      = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_START  = 2'd2,
        CMD_STOP   = 2'd3
    } cmd_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_EMIT
    } seq_state_t;

    // store control from the sequencer
    typedef struct packed {
        logic wr_en;
        logic clear;
    } store_ctrl_t;

    // one readout step from the sequencer
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CHAN_W-1:0] chan;
    } emit_t;

endpackage

`default_nettype wire

FILE: rtl/acsc_in_if.sv
// interface: input item channel of the sample cache
`default_nettype none

interface acsc_in_if
    import acsc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [WORD_W-1:0]    raw_word;
    logic [MASK_W-1:0]    read_mask;
    logic [COUNT_W-1:0]   read_count;

    modport source (output valid, output cmd, output raw_word, output read_mask,
                    output read_count, input ready);
    modport sink   (input valid, input cmd, input raw_word, input read_mask,
                    input read_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/acsc_out_if.sv
// interface: result item channel of the sample cache
`default_nettype none

interface acsc_out_if
    import acsc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [SAMPLE_W-1:0]  sample_value;
    logic [CHAN_W-1:0]    channel_index;
    logic                 last_item;

    modport source (output valid, output sample_value, output channel_index,
                    output last_item, input ready);
    modport sink   (input valid, input sample_value, input channel_index,
                    input last_item, output ready);
endinterface

`default_nettype wire

FILE: rtl/acsc_store.sv
// module: per-channel sample registers with valid bits
`default_nettype none

module acsc_store
    import acsc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire store_ctrl_t         ctrl,
    input  wire logic [IDX_W-1:0]    wr_idx,
    input  wire logic [SAMPLE_W-1:0] wr_data,
    input  wire logic [IDX_W-1:0]    rd_idx,
    output logic [SAMPLE_W-1:0]      rd_data
);

    logic [NUM_CHANNELS-1:0] valid_reg;
    logic [SAMPLE_W-1:0]     data_reg [NUM_CHANNELS];

    // valid bits: cleared by reset and by stop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // sample data, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            data_reg[wr_idx] <= wr_data;
        end
    end

    // an entry never written since clear reads as zero
    assign rd_data = valid_reg[rd_idx] ? data_reg[rd_idx] : '0;

endmodule

`default_nettype wire

FILE: rtl/acsc_seq.sv
// module: command decode and readout sequencer with shared lowest-bit picker
`default_nettype none

module acsc_seq
    import acsc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_accept,
    input  wire logic [CMD_W-1:0]   cmd,
    input  wire logic [WORD_CHAN_W-1:0] word_chan,
    input  wire logic [MASK_W-1:0]  read_mask,
    input  wire logic [COUNT_W-1:0] read_count,
    input  wire logic               slot_free,
    output logic                    ready,
    output store_ctrl_t             store_ctrl,
    output emit_t                   emit
);

    localparam int LIMIT = (NUM_CHANNELS < MAX_OUT) ? NUM_CHANNELS : MAX_OUT;
    localparam logic [MASK_W-1:0] LIMIT_MASK = MASK_W'((1 << LIMIT) - 1);

    seq_state_t          state_reg, state_next;
    logic                enable_reg, enable_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [CHAN_W-1:0]   pick;
    logic                step;
    cmd_t                cmd_code;
    logic                chan_ok;

    assign cmd_code = cmd_t'(cmd);
    assign chan_ok  = ({1'b0, word_chan} < (WORD_CHAN_W + 1)'(NUM_CHANNELS));

    // lowest set bit of the remaining mask, channel 0 once it is empty
    always_comb
    begin
        pick = '0;
        for (int b = MASK_W - 1; b >= 0; b--)
        begin
            if (mask_reg[b])
            begin
                pick = CHAN_W'(b);
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            enable_reg <= 1'b0;
            mask_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            enable_reg <= enable_next;
            mask_reg   <= mask_next;
            count_reg  <= count_next;
        end
    end

    // next state and outputs
    always_comb
    begin
        state_next       = state_reg;
        enable_next      = enable_reg;
        mask_next        = mask_reg;
        count_next       = count_reg;
        ready            = 1'b0;
        step             = 1'b0;
        store_ctrl.wr_en = 1'b0;
        store_ctrl.clear = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                ready = 1'b1;
                if (in_accept)
                begin
                    unique case (cmd_code)
                        CMD_SAMPLE:
                        begin
                            store_ctrl.wr_en = enable_reg && chan_ok;
                        end
                        CMD_READ:
                        begin
                            if (read_count >= COUNT_W'(MAX_OUT))
                            begin
                                // all-channel mode is a full mask of limit picks
                                mask_next  = LIMIT_MASK;
                                count_next = COUNT_W'(LIMIT);
                                state_next = SEQ_EMIT;
                            end
                            else if (read_count != '0)
                            begin
                                mask_next  = read_mask & LIMIT_MASK;
                                count_next = read_count;
                                state_next = SEQ_EMIT;
                            end
                        end
                        CMD_START:
                        begin
                            enable_next = 1'b1;
                        end
                        CMD_STOP:
                        begin
                            enable_next      = 1'b0;
                            store_ctrl.clear = 1'b1;
                        end
                        default:
                        begin
                            enable_next = enable_reg;
                        end
                    endcase
                end
            end
            SEQ_EMIT:
            begin
                step = slot_free;
                if (slot_free)
                begin
                    mask_next  = mask_reg & ~(MASK_W'(1) << pick);
                    count_next = count_reg - COUNT_W'(1);
                    if (count_reg == COUNT_W'(1))
                    begin
                        state_next = SEQ_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign emit.valid = step;
    assign emit.last  = (count_reg == COUNT_W'(1));
    assign emit.chan  = pick;

endmodule

`default_nettype wire

FILE: rtl/adc_channel_sample_cache_top.sv
// Sample cache for a multi-channel converter: keeps the latest sample per channel.
// Input channel in_ch carries one command item: sample word, read request,
// start or stop. Output channel out_ch carries the stored samples that a read
// request asks for, one item per sample, the final one flagged by last_item.
// Sample, start and stop items leave in_ch.ready high, so they can follow back
// to back. A read request with count n (n = 8 or more meaning every channel)
// keeps in_ch.ready low while the sequencer walks the mask with its lowest-bit
// picker, one result a cycle into the output register while it has room; the
// first result passes the state register and then the output register before
// it shows on out_ch. Pick and store read of a result fall in the same cycle.
// When out_ch stalls, the output register holds its item and the sequencer
// waits; the block takes a new item in the cycle after the last result has
// entered the output register, while that result may still wait there.
// Reset (rst_n, asynchronous, low) clears all stored samples to zero, turns
// capture off and empties the output register; there is no clearing pass.
// Stop also clears every stored sample.
`default_nettype none
`include "adc_channel_sample_cache_top_macros.svh"

module adc_channel_sample_cache_top
    import acsc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    acsc_in_if.sink    in_ch,
    acsc_out_if.source out_ch
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int LIMIT = (NUM_CHANNELS < MAX_OUT) ? NUM_CHANNELS : MAX_OUT;

    logic                in_accept;
    logic                slot_free;
    logic                seq_ready;
    store_ctrl_t         store_ctrl;
    emit_t               emit;
    logic [SAMPLE_W-1:0] rd_data;

    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic [CHAN_W-1:0]   out_chan_reg;
    logic                out_last_reg;

    assign in_ch.ready = seq_ready;
    assign in_accept   = in_ch.valid && seq_ready;
    assign slot_free   = !out_valid_reg || out_ch.ready;

    // sequencer
    acsc_seq #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .cmd        (in_ch.cmd),
        .word_chan  (in_ch.raw_word[WORD_CHAN_W-1:0]),
        .read_mask  (in_ch.read_mask),
        .read_count (in_ch.read_count),
        .slot_free  (slot_free),
        .ready      (seq_ready),
        .store_ctrl (store_ctrl),
        .emit       (emit)
    );

    // sample store
    acsc_store #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (store_ctrl),
        .wr_idx  (IDX_W'(in_ch.raw_word[WORD_CHAN_W-1:0])),
        .wr_data (in_ch.raw_word[SAMPLE_LSB +: SAMPLE_W]),
        .rd_idx  (IDX_W'(emit.chan)),
        .rd_data (rd_data)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_sample_reg <= rd_data;
            out_chan_reg   <= emit.chan;
            out_last_reg   <= emit.last;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.sample_value  = out_sample_reg;
    assign out_ch.channel_index = out_chan_reg;
    assign out_ch.last_item     = out_last_reg;

    // checks on the sequencer and output register
    `ACSC_ASSERT_NOW(a_idle_no_emit, seq_ready, !emit.valid)
    `ACSC_ASSERT_NEXT(a_last_then_ready, emit.valid && emit.last, seq_ready && out_valid_reg)
    `ACSC_ASSERT_NOW(a_chan_in_range, emit.valid, {1'b0, emit.chan} < (CHAN_W + 1)'(LIMIT))

endmodule

`default_nettype wire
